// ===== design/nnis_pkg.sv =====
package nnis_pkg;

  localparam int unsigned PIX_W   = 32;
  localparam int unsigned CFG_W   = 9;
  localparam int unsigned CFG_N   = 4;
  localparam int unsigned CFG_IW  = $clog2(CFG_N);
  localparam int unsigned DCNT_W  = $clog2(CFG_W);

  localparam logic [CFG_IW-1:0] REG_SRC_WIDTH  = CFG_IW'(0);
  localparam logic [CFG_IW-1:0] REG_SRC_HEIGHT = CFG_IW'(1);
  localparam logic [CFG_IW-1:0] REG_DST_WIDTH  = CFG_IW'(2);
  localparam logic [CFG_IW-1:0] REG_DST_HEIGHT = CFG_IW'(3);

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_ADDR,
    ST_READ
  } state_e;

  // zero acts as one, anything above the frame limit acts as the limit
  function automatic logic [CFG_W-1:0] dim_clamp(input logic [CFG_W-1:0] v,
                                                 input int unsigned max_dim);
    logic [CFG_W-1:0] r;
    if (v == '0) begin
      r = CFG_W'(1);
    end else if (32'(v) > max_dim) begin
      r = CFG_W'(max_dim);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ===== design/nearest_neighbor_image_scaler_core.sv =====
// Nearest-neighbor image scaler. A load request (action 0) writes one source pixel into the
// frame store in raster order; the write address wraps to zero after src_width*src_height
// pixels. A tick request (action 1) produces the next pixel of the dst_width x dst_height
// output frame in raster order, with frame_last set on the final pixel. Accepting a tick
// forms col*src_width and row*src_height; the two shift-subtract dividers then run side by
// side (one quotient bit per cycle), the store address is formed, and the store read's
// registered data is the output pixel. The result waits in the output register while the
// block takes further requests; a second tick holds at its store read until the first result
// is taken. The user must write the registers only while the block is idle; the block itself
// does not enforce this. The store holds no reset value, so ticks are meaningful only after
// a full source frame is loaded.
module nearest_neighbor_image_scaler_core #(
  parameter int unsigned MAX_DIM = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          action_i,
  input  logic [nnis_pkg::PIX_W-1:0]    src_pixel_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [nnis_pkg::PIX_W-1:0]    out_pixel_o,
  output logic                          frame_last_o,
  input  logic                          cfg_we_i,
  input  logic [nnis_pkg::CFG_IW-1:0]   cfg_index_i,
  input  logic [nnis_pkg::CFG_W-1:0]    cfg_wdata_i
);

  localparam int unsigned CW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned DW    = nnis_pkg::CFG_W;
  localparam int unsigned CMPW  = (CW > DW) ? CW : DW;
  localparam int unsigned NW    = CW + DW;
  localparam int unsigned DVW   = 2 * DW - 1;
  localparam int unsigned WW    = (NW > DVW) ? NW : DVW;
  localparam int unsigned PW    = 2 * DW;
  localparam int unsigned LCW   = ((AW > PW) ? AW : PW) + 1;

  logic [DW-1:0] src_width_q, src_height_q, dst_width_q, dst_height_q;
  logic [DW-1:0] sw, sh, dw, dh;

  nnis_pkg::state_e state_q, state_d;

  logic [AW-1:0] load_addr_q, load_addr_d;
  logic [CW-1:0] out_col_q, out_col_d, out_row_q, out_row_d;

  logic [WW-1:0] rem_x_q, rem_y_q, dv_x_q, dv_y_q;
  logic [DW-1:0] quo_x_q, quo_y_q;
  logic [nnis_pkg::DCNT_W-1:0] div_cnt_q;
  logic          last_q;
  logic [AW-1:0] rd_addr_q;

  logic [nnis_pkg::PIX_W-1:0] frame_store_q [DEPTH];
  logic [nnis_pkg::PIX_W-1:0] rd_data_q;
  logic                       out_valid_q;
  logic                       out_last_q;

  logic in_acc, load_acc, tick_acc, rd_en, div_done;

  logic [PW-1:0]  frame_size;
  logic [LCW-1:0] ld_cur, ld_inc;

  logic [CW-1:0] col_eff, row_eff;
  logic          last_col, last_row;
  logic [PW:0]   addr_sum;

  assign sw = nnis_pkg::dim_clamp(src_width_q, MAX_DIM);
  assign sh = nnis_pkg::dim_clamp(src_height_q, MAX_DIM);
  assign dw = nnis_pkg::dim_clamp(dst_width_q, MAX_DIM);
  assign dh = nnis_pkg::dim_clamp(dst_height_q, MAX_DIM);

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q  <= DW'(1);
      src_height_q <= DW'(1);
      dst_width_q  <= DW'(1);
      dst_height_q <= DW'(1);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        nnis_pkg::REG_SRC_WIDTH:  src_width_q  <= cfg_wdata_i;
        nnis_pkg::REG_SRC_HEIGHT: src_height_q <= cfg_wdata_i;
        nnis_pkg::REG_DST_WIDTH:  dst_width_q  <= cfg_wdata_i;
        nnis_pkg::REG_DST_HEIGHT: dst_height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      nnis_pkg::ST_IDLE: if (tick_acc) state_d = nnis_pkg::ST_DIV;
      nnis_pkg::ST_DIV:  if (div_done) state_d = nnis_pkg::ST_ADDR;
      nnis_pkg::ST_ADDR: state_d = nnis_pkg::ST_READ;
      nnis_pkg::ST_READ: if (rd_en) state_d = nnis_pkg::ST_IDLE;
      default:           state_d = nnis_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall_o = 1'b1;
    rd_en      = 1'b0;
    div_done   = 1'b0;
    case (state_q)
      nnis_pkg::ST_IDLE: in_stall_o = 1'b0;
      nnis_pkg::ST_DIV:  div_done = (div_cnt_q == nnis_pkg::DCNT_W'(DW - 1));
      nnis_pkg::ST_ADDR: ;
      nnis_pkg::ST_READ: rd_en = !out_valid_q || !out_stall_i;
      default: ;
    endcase
  end

  assign in_acc   = in_valid_i && !in_stall_o;
  assign load_acc = in_acc && (action_i == nnis_pkg::ACT_LOAD);
  assign tick_acc = in_acc && (action_i == nnis_pkg::ACT_TICK);

  // load address with wrap and stale-address fallback
  assign frame_size = PW'(sw) * PW'(sh);
  assign ld_cur = (LCW'(load_addr_q) >= LCW'(frame_size)) ? '0 : LCW'(load_addr_q);
  assign ld_inc = ld_cur + LCW'(1);
  assign load_addr_d = (ld_inc >= LCW'(frame_size)) ? '0 : AW'(ld_inc);

  // output raster position
  assign col_eff  = (CMPW'(out_col_q) < CMPW'(dw)) ? out_col_q : '0;
  assign row_eff  = (CMPW'(out_row_q) < CMPW'(dh)) ? out_row_q : '0;
  assign last_col = (CMPW'(col_eff) == CMPW'(dw) - CMPW'(1));
  assign last_row = (CMPW'(row_eff) == CMPW'(dh) - CMPW'(1));

  always_comb begin
    out_col_d = col_eff + CW'(1);
    out_row_d = row_eff;
    if (last_col) begin
      out_col_d = '0;
      out_row_d = last_row ? '0 : row_eff + CW'(1);
    end
  end

  assign addr_sum = (PW+1)'(PW'(quo_y_q) * PW'(sw)) + (PW+1)'(quo_x_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= nnis_pkg::ST_IDLE;
      load_addr_q <= '0;
      out_col_q   <= '0;
      out_row_q   <= '0;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_acc) begin
        load_addr_q <= load_addr_d;
      end
      if (tick_acc) begin
        out_col_q <= out_col_d;
        out_row_q <= out_row_d;
        div_cnt_q <= '0;
      end else if (state_q == nnis_pkg::ST_DIV) begin
        div_cnt_q <= div_cnt_q + nnis_pkg::DCNT_W'(1);
      end
      if (rd_en) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // two shift-subtract dividers, one quotient bit per cycle
  always_ff @(posedge clk_i) begin
    if (tick_acc) begin
      rem_x_q <= WW'(NW'(col_eff) * NW'(sw));
      rem_y_q <= WW'(NW'(row_eff) * NW'(sh));
      dv_x_q  <= WW'(dw) << (DW - 1);
      dv_y_q  <= WW'(dh) << (DW - 1);
      quo_x_q <= '0;
      quo_y_q <= '0;
      last_q  <= last_col && last_row;
    end else if (state_q == nnis_pkg::ST_DIV) begin
      if (rem_x_q >= dv_x_q) begin
        rem_x_q <= rem_x_q - dv_x_q;
        quo_x_q <= {quo_x_q[DW-2:0], 1'b1};
      end else begin
        quo_x_q <= {quo_x_q[DW-2:0], 1'b0};
      end
      if (rem_y_q >= dv_y_q) begin
        rem_y_q <= rem_y_q - dv_y_q;
        quo_y_q <= {quo_y_q[DW-2:0], 1'b1};
      end else begin
        quo_y_q <= {quo_y_q[DW-2:0], 1'b0};
      end
      dv_x_q <= dv_x_q >> 1;
      dv_y_q <= dv_y_q >> 1;
    end
    if (state_q == nnis_pkg::ST_ADDR) begin
      rd_addr_q <= AW'(addr_sum);
    end
    if (rd_en) begin
      out_last_q <= last_q;
    end
  end

  // frame store
  always_ff @(posedge clk_i) begin
    if (load_acc) begin
      frame_store_q[AW'(ld_cur)] <= src_pixel_i;
    end
    if (rd_en) begin
      rd_data_q <= frame_store_q[rd_addr_q];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_pixel_o  = rd_data_q;
  assign frame_last_o = out_last_q;

endmodule

// ===== dv/nnis_scaler_checker.sv =====
`timescale 1ns / 100ps
module nnis_scaler_checker #(
  parameter int unsigned MAX_DIM = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic                          action_i,
  input  logic [nnis_pkg::PIX_W-1:0]    src_pixel_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic [nnis_pkg::PIX_W-1:0]    out_pixel_i,
  input  logic                          frame_last_i,
  input  logic                          cfg_we_i,
  input  logic [nnis_pkg::CFG_IW-1:0]   cfg_index_i,
  input  logic [nnis_pkg::CFG_W-1:0]    cfg_wdata_i,
  output int unsigned                   errors_o,
  output int unsigned                   pending_o
);

  typedef struct packed {
    logic [nnis_pkg::PIX_W-1:0] pixel;
    logic                       last;
  } scaled_pix_t;

  logic [nnis_pkg::PIX_W-1:0] frame_mem [MAX_DIM*MAX_DIM];
  logic [nnis_pkg::CFG_W-1:0] dim_regs [nnis_pkg::CFG_N];
  int unsigned                load_ptr;
  int unsigned                col_q;
  int unsigned                row_q;
  int unsigned                mismatches;
  scaled_pix_t                expected_pixels [$];

  function automatic int unsigned eff_dim(logic [nnis_pkg::CFG_W-1:0] v);
    if (v == '0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return 32'(v);
  endfunction

  task automatic advance_scaler(logic act, logic [nnis_pkg::PIX_W-1:0] pix);
    int unsigned sw, sh, dw, dh, frame, addr, col, row;
    scaled_pix_t nxt;
    sw = eff_dim(dim_regs[nnis_pkg::REG_SRC_WIDTH]);
    sh = eff_dim(dim_regs[nnis_pkg::REG_SRC_HEIGHT]);
    dw = eff_dim(dim_regs[nnis_pkg::REG_DST_WIDTH]);
    dh = eff_dim(dim_regs[nnis_pkg::REG_DST_HEIGHT]);
    if (act == nnis_pkg::ACT_LOAD) begin
      frame = sw * sh;
      addr = (load_ptr >= frame) ? 0 : load_ptr;
      frame_mem[addr] = pix;
      load_ptr = (addr + 1 >= frame) ? 0 : addr + 1;
    end else begin
      // counters left over from a larger frame restart at zero
      col = (col_q < dw) ? col_q : 0;
      row = (row_q < dh) ? row_q : 0;
      addr = ((row * sh) / dh) * sw + (col * sw) / dw;
      nxt.pixel = frame_mem[addr];
      nxt.last = (col == dw - 1) && (row == dh - 1);
      expected_pixels.push_back(nxt);
      if (col == dw - 1) begin
        col_q = 0;
        row_q = (row == dh - 1) ? 0 : row + 1;
      end else begin
        col_q = col + 1;
        row_q = row;
      end
    end
  endtask

  task automatic check_out_pixel();
    scaled_pix_t nxt;
    if (expected_pixels.size() == 0) begin
      if (mismatches < 10) begin
        $display("%0t: output pixel %h last %b with no request pending", $realtime,
                 out_pixel_i, frame_last_i);
      end
      mismatches++;
    end else begin
      nxt = expected_pixels.pop_front();
      if (out_pixel_i !== nxt.pixel || frame_last_i !== nxt.last) begin
        if (mismatches < 10) begin
          $display("%0t: out_pixel exp %h got %h, frame_last exp %b got %b", $realtime,
                   nxt.pixel, out_pixel_i, nxt.last, frame_last_i);
        end
        mismatches++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < nnis_pkg::CFG_N; k++) dim_regs[k] = nnis_pkg::CFG_W'(1);
      load_ptr = 0;
      col_q = 0;
      row_q = 0;
      mismatches = 0;
      expected_pixels.delete();
    end else begin
      if (out_valid_i && !out_stall_i) check_out_pixel();
      if (cfg_we_i) dim_regs[cfg_index_i] = cfg_wdata_i;
      if (in_valid_i && !in_stall_i) advance_scaler(action_i, src_pixel_i);
    end
    errors_o <= mismatches;
    pending_o <= expected_pixels.size();
  end

endmodule

// ===== dv/tb_nearest_neighbor_image_scaler_core.sv =====
`timescale 1ns / 100ps
module tb_nearest_neighbor_image_scaler_core;

  localparam int unsigned MAX_DIM      = 256;
  localparam int unsigned ITEM_TARGET  = 1300;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned CYCLE_LIMIT  = 600000;

  logic                        clk = 1'b0;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_stall;
  logic                        action;
  logic [nnis_pkg::PIX_W-1:0]  src_pixel;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [nnis_pkg::PIX_W-1:0]  out_pixel;
  logic                        frame_last;
  logic                        cfg_we;
  logic [nnis_pkg::CFG_IW-1:0] cfg_index;
  logic [nnis_pkg::CFG_W-1:0]  cfg_wdata;
  int unsigned                 mismatch_cnt;
  int unsigned                 pending_cnt;

  int unsigned cycles = 0;
  int unsigned sent = 0;
  int unsigned covered = 0;
  int unsigned send_idle_pct = 18;
  int unsigned recv_idle_pct = 67;

  always #4 clk = ~clk;

  nearest_neighbor_image_scaler_core #(
    .MAX_DIM (MAX_DIM)
  ) i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .action_i     (action),
    .src_pixel_i  (src_pixel),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .out_pixel_o  (out_pixel),
    .frame_last_o (frame_last),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_wdata_i  (cfg_wdata)
  );

  nnis_scaler_checker #(
    .MAX_DIM (MAX_DIM)
  ) i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .action_i     (action),
    .src_pixel_i  (src_pixel),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_pixel_i  (out_pixel),
    .frame_last_i (frame_last),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_wdata_i  (cfg_wdata),
    .errors_o     (mismatch_cnt),
    .pending_o    (pending_cnt)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  function automatic int unsigned dim_eff(logic [nnis_pkg::CFG_W-1:0] v);
    if (v == '0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return 32'(v);
  endfunction

  task automatic send_req(logic act, logic [nnis_pkg::PIX_W-1:0] pix);
    if (sent < ITEM_TARGET / 3) begin
      send_idle_pct = 18;
      recv_idle_pct = 67;
    end else if (sent < 2 * ITEM_TARGET / 3) begin
      send_idle_pct = 67;
      recv_idle_pct = 18;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    src_pixel <= pix;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  // hold requests until every tick has come back, then let the block settle
  task automatic wait_scaler_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_cnt != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_dims(logic [nnis_pkg::CFG_W-1:0] sw, logic [nnis_pkg::CFG_W-1:0] sh,
                            logic [nnis_pkg::CFG_W-1:0] dw, logic [nnis_pkg::CFG_W-1:0] dh);
    cfg_we <= 1'b1;
    cfg_index <= nnis_pkg::REG_SRC_WIDTH;
    cfg_wdata <= sw;
    @(posedge clk);
    cfg_index <= nnis_pkg::REG_SRC_HEIGHT;
    cfg_wdata <= sh;
    @(posedge clk);
    cfg_index <= nnis_pkg::REG_DST_WIDTH;
    cfg_wdata <= dw;
    @(posedge clk);
    cfg_index <= nnis_pkg::REG_DST_HEIGHT;
    cfg_wdata <= dh;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(logic [nnis_pkg::CFG_W-1:0] sw, logic [nnis_pkg::CFG_W-1:0] sh,
                           logic [nnis_pkg::CFG_W-1:0] dw, logic [nnis_pkg::CFG_W-1:0] dh,
                           int unsigned ticks);
    int unsigned frame;
    int unsigned drain_at;
    wait_scaler_idle();
    write_dims(sw, sh, dw, dh);
    frame = dim_eff(sw) * dim_eff(sh);
    // a tick must never read a store entry that was never written
    if (frame > covered || $urandom_range(0, 4) != 0) begin
      repeat (frame) send_req(nnis_pkg::ACT_LOAD, $urandom());
      if (frame > covered) covered = frame;
    end
    drain_at = $urandom_range(0, ticks);
    for (int i = 0; i < ticks; i++) begin
      if (i == drain_at) wait_scaler_idle();
      if ($urandom_range(0, 9) == 0) send_req(nnis_pkg::ACT_LOAD, $urandom());
      send_req(nnis_pkg::ACT_TICK, $urandom());
    end
  endtask

  initial begin
    logic [nnis_pkg::CFG_W-1:0] sw, sh, dw, dh;
    int unsigned phase;
    rst_n = 1'b0;
    in_valid = 1'b0;
    action = nnis_pkg::ACT_LOAD;
    src_pixel = '0;
    cfg_we = 1'b0;
    cfg_index = nnis_pkg::REG_SRC_WIDTH;
    cfg_wdata = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset dimensions: 1x1 to 1x1
    send_req(nnis_pkg::ACT_LOAD, 32'hFFFF_FFFF);
    send_req(nnis_pkg::ACT_TICK, 32'h0000_0000);
    send_req(nnis_pkg::ACT_TICK, 32'hFFFF_FFFF);
    send_req(nnis_pkg::ACT_LOAD, 32'h0000_0000);
    send_req(nnis_pkg::ACT_TICK, 32'h0000_0000);
    covered = 1;

    // zero dimensions act as one
    wait_scaler_idle();
    write_dims('0, '0, '0, '0);
    send_req(nnis_pkg::ACT_LOAD, 32'hA5A5_A5A5);
    send_req(nnis_pkg::ACT_TICK, 32'h0000_0000);

    // 2x2 upscaled to 3x3, stopped mid-frame with an extra load
    wait_scaler_idle();
    write_dims(nnis_pkg::CFG_W'(2), nnis_pkg::CFG_W'(2),
               nnis_pkg::CFG_W'(3), nnis_pkg::CFG_W'(3));
    send_req(nnis_pkg::ACT_LOAD, 32'h1111_1111);
    send_req(nnis_pkg::ACT_LOAD, 32'h2222_2222);
    send_req(nnis_pkg::ACT_LOAD, 32'h3333_3333);
    send_req(nnis_pkg::ACT_LOAD, 32'h4444_4444);
    covered = 4;
    repeat (7) send_req(nnis_pkg::ACT_TICK, $urandom());
    send_req(nnis_pkg::ACT_LOAD, 32'h5555_5555);

    // shrink both frames: stale load address and stale output counters
    wait_scaler_idle();
    write_dims(nnis_pkg::CFG_W'(1), nnis_pkg::CFG_W'(1),
               nnis_pkg::CFG_W'(1), nnis_pkg::CFG_W'(1));
    send_req(nnis_pkg::ACT_LOAD, 32'h6666_6666);
    send_req(nnis_pkg::ACT_TICK, 32'h0000_0000);
    send_req(nnis_pkg::ACT_TICK, 32'h0000_0000);

    phase = 0;
    while (sent < ITEM_TARGET) begin
      case (phase)
        4: run_phase(nnis_pkg::CFG_W'(256), nnis_pkg::CFG_W'(1),
                     nnis_pkg::CFG_W'(511), nnis_pkg::CFG_W'(1), 258);
        9: run_phase(nnis_pkg::CFG_W'(0), nnis_pkg::CFG_W'(511),
                     nnis_pkg::CFG_W'(1), nnis_pkg::CFG_W'(256), 60);
        14: run_phase(nnis_pkg::CFG_W'(3), nnis_pkg::CFG_W'(2),
                      nnis_pkg::CFG_W'(300), nnis_pkg::CFG_W'(2), 40);
        default: begin
          sw = ($urandom_range(0, 9) == 0) ? '0 : nnis_pkg::CFG_W'($urandom_range(1, 8));
          sh = ($urandom_range(0, 9) == 0) ? '0 : nnis_pkg::CFG_W'($urandom_range(1, 8));
          dw = ($urandom_range(0, 9) == 0) ? '0 : nnis_pkg::CFG_W'($urandom_range(1, 10));
          dh = ($urandom_range(0, 9) == 0) ? '0 : nnis_pkg::CFG_W'($urandom_range(1, 10));
          run_phase(sw, sh, dw, dh, $urandom_range(1, 2 * dim_eff(dw) * dim_eff(dh) + 3));
        end
      endcase
      phase++;
    end

    wait_scaler_idle();
    if (mismatch_cnt == 0 && pending_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
